FILE: src/sbd_pkg.sv
package sbd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_WINDOW_LEN   = 2'd0;
  localparam logic [1:0] REG_NOISE_FACTOR = 2'd1;
  localparam logic [1:0] REG_SD_FACTOR    = 2'd2;
  localparam logic [1:0] REG_SLOW_SHIFT   = 2'd3;

  localparam int IDX_W  = 2;
  localparam int CFG_W  = 11;
  localparam int WIN_W  = 10;
  localparam int NF_W   = 8;
  localparam int SD_W   = 11;
  localparam int SH_W   = 5;
  localparam int CNT_W  = 32;

  // Reset values and write limits of the registers
  localparam int WIN_RST = 500;
  localparam logic [NF_W-1:0] NF_RST = 8'd64;
  localparam logic [SD_W-1:0] SD_RST = 11'd614;
  localparam logic [SH_W-1:0] SH_RST = 5'd13;
  localparam logic [SH_W-1:0] SH_MIN = 5'd4;
  localparam logic [SH_W-1:0] SH_MAX = 5'd20;
  localparam logic [WIN_W-1:0] WIN_MIN = 10'd2;

  // Fraction bits and reset level of the slow average, alignment of the noise test
  localparam int AVG_FRAC    = 20;
  localparam int NOISE_SHIFT = 28;
  localparam int AVG_ONE     = 256;

endpackage

FILE: src/spectral_beat_detector.sv
// Spectral beat detector.
// in_* carries one spectrum frame per transaction: BANDS magnitudes of
// MAG_BITS each. out_* returns one result per frame: beat flag, per-band
// mask and the running count of rising beat edges.
// cfg_* writes a register at any edge with cfg_wr_en high; the user
// writes in idle only, a rule unenforced by the block. Each frame is
// worked through ten products per band on one shift-and-add multiplier; a
// product runs until no bits of its second operand are left. A frame goes
// through the history read, the products, the write-back and the output
// register before the next is taken; in_tready is low for the whole frame.
// After reset, and after every write of window_len, a clearing pass walks
// the history memory one entry a cycle, all MAX_WINDOW entries, before the
// first frame is taken.
// The result sits in an output register; while the receiver stalls the
// block finishes the next frame and then holds it until out_tready.
module spectral_beat_detector #(
  parameter int MAX_WINDOW = 512,
  parameter int BANDS      = 3,
  parameter int MAG_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  // fields from bit 0: mag_low, mag_mid, mag_high (one per band)
  input  logic [((BANDS*MAG_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // fields from bit 0: beat, band_beats, beat_count
  output logic [((33+BANDS+7)/8)*8-1:0]       out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [sbd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int M    = MAG_BITS;
  localparam int HW   = BANDS * M;
  localparam int OW   = ((33+BANDS+7)/8)*8;
  localparam int AD   = $clog2(MAX_WINDOW);
  localparam int BNW  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int SW   = M + sbd_pkg::WIN_W;
  localparam int QW   = 2*M + sbd_pkg::WIN_W;
  localparam int LW   = M + sbd_pkg::AVG_FRAC + 1;
  localparam int PRW  = 2*M + 44;
  localparam int BW   = M + 18;
  localparam int WRST = (sbd_pkg::WIN_RST < MAX_WINDOW) ? sbd_pkg::WIN_RST : MAX_WINDOW;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_RDW, ST_MST, ST_MWT, ST_WB, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_XX, OP_OO, OP_NF, OP_NZ, OP_NX, OP_NQ, OP_SS, OP_DD, OP_K2, OP_VK
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [sbd_pkg::WIN_W-1:0] win_r;
  logic [sbd_pkg::NF_W-1:0]  nf_r;
  logic [sbd_pkg::SD_W-1:0]  sd_r;
  logic [sbd_pkg::SH_W-1:0]  sh_r;

  logic [SW-1:0]  sum_r [BANDS];
  logic [QW-1:0]  sq_r  [BANDS];
  logic [LW-1:0]  avg_r [BANDS];

  logic [AD-1:0]  pos_r;
  logic [AD-1:0]  clr_r;
  logic [BNW-1:0] band_r;
  logic [HW-1:0]  in_word_r;
  logic [HW-1:0]  old_word_r;
  logic [QW-1:0]  xx_r;
  logic [BW-1:0]  p_r;
  logic [BW-1:0]  d_r;
  logic [BW-1:0]  k2_r;
  logic [PRW-1:0] nq_r;
  logic [PRW-1:0] var_r;
  logic [PRW-1:0] dd_r;
  logic           quiet_r;
  logic           dpos_r;
  logic [BANDS-1:0] mask_r;
  logic           prev_r;
  logic [sbd_pkg::CNT_W-1:0] cnt_r;
  logic [OW-1:0]  out_data_r;
  logic           out_valid_r;

  // Multiplier and memory hookup
  logic           mul_start;
  logic [PRW-1:0] mul_a;
  logic [BW-1:0]  mul_b;
  logic           mul_done;
  logic [PRW-1:0] mul_p;
  logic           ram_we;
  logic [AD-1:0]  ram_addr;
  logic [HW-1:0]  ram_wdata;
  logic [HW-1:0]  ram_rdata;

  sbd_mul #(.AW(PRW), .BW(BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  sbd_ram #(.WIDTH(HW), .DEPTH(MAX_WINDOW)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_WB);
  assign ram_addr  = (state_r == ST_CLR) ? clr_r : pos_r;
  assign ram_wdata = (state_r == ST_CLR) ? '0 : in_word_r;
  assign mul_start = (state_r == ST_MST);

  // Current band's operands
  logic [M-1:0]   x_cur;
  logic [M-1:0]   old_cur;
  logic [SW-1:0]  s_cur;
  logic [QW-1:0]  q_cur;
  logic [LW-1:0]  l_cur;
  logic [LW-1:0]  target;
  logic [LW-1:0]  l_upd;
  logic [SW-1:0]  nx;
  logic [PRW-1:0] noise_rhs;

  always_comb begin
    x_cur     = in_word_r[band_r*M +: M];
    old_cur   = old_word_r[band_r*M +: M];
    s_cur     = sum_r[band_r];
    q_cur     = sq_r[band_r];
    l_cur     = avg_r[band_r];
    target    = LW'(x_cur) << sbd_pkg::AVG_FRAC;
    if (target >= l_cur) begin
      l_upd = l_cur + ((target - l_cur) >> sh_r);
    end else begin
      l_upd = l_cur - ((l_cur - target) >> sh_r);
    end
    nx        = mul_p[SW-1:0];
    noise_rhs = PRW'(s_cur) << sbd_pkg::NOISE_SHIFT;
  end

  // Operand selection per product
  always_comb begin
    case (op_r)
      OP_XX:   begin mul_a = PRW'(x_cur);   mul_b = BW'(x_cur);   end
      OP_OO:   begin mul_a = PRW'(old_cur); mul_b = BW'(old_cur); end
      OP_NF:   begin mul_a = PRW'(nf_r);    mul_b = BW'(win_r);   end
      OP_NZ:   begin mul_a = PRW'(l_cur);   mul_b = p_r;          end
      OP_NX:   begin mul_a = PRW'(x_cur);   mul_b = BW'(win_r);   end
      OP_NQ:   begin mul_a = PRW'(q_cur);   mul_b = BW'(win_r);   end
      OP_SS:   begin mul_a = PRW'(s_cur);   mul_b = BW'(s_cur);   end
      OP_DD:   begin mul_a = PRW'(d_r);     mul_b = d_r;          end
      OP_K2:   begin mul_a = PRW'(sd_r);    mul_b = BW'(sd_r);    end
      OP_VK:   begin mul_a = var_r;         mul_b = k2_r;         end
      default: begin mul_a = '0;            mul_b = '0;           end
    endcase
  end

  logic [sbd_pkg::WIN_W-1:0] win_wr;
  logic [sbd_pkg::SH_W-1:0]  sh_wr;
  logic                      beat_now;
  logic [AD:0]               pos_inc;
  logic                      win_clr;
  logic                      out_load;

  always_comb begin
    win_wr = cfg_wdata[sbd_pkg::WIN_W-1:0];
    if (win_wr < sbd_pkg::WIN_MIN) begin
      win_wr = sbd_pkg::WIN_MIN;
    end else if (32'(win_wr) > MAX_WINDOW) begin
      win_wr = sbd_pkg::WIN_W'(MAX_WINDOW);
    end
    sh_wr = cfg_wdata[sbd_pkg::SH_W-1:0];
    if (sh_wr < sbd_pkg::SH_MIN) begin
      sh_wr = sbd_pkg::SH_MIN;
    end else if (sh_wr > sbd_pkg::SH_MAX) begin
      sh_wr = sbd_pkg::SH_MAX;
    end
    beat_now = |mask_r;
    pos_inc  = {1'b0, pos_r} + 1'b1;
    // window_len write restarts the clearing pass
    win_clr  = cfg_wr_en && (cfg_index == sbd_pkg::REG_WINDOW_LEN);
    out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready) && !win_clr;
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      op_r        <= OP_XX;
      clr_r       <= '0;
      pos_r       <= '0;
      band_r      <= '0;
      prev_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      win_r       <= sbd_pkg::WIN_W'(WRST);
      nf_r        <= sbd_pkg::NF_RST;
      sd_r        <= sbd_pkg::SD_RST;
      sh_r        <= sbd_pkg::SH_RST;
      for (int i = 0; i < BANDS; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
        avg_r[i] <= LW'(sbd_pkg::AVG_ONE) << sbd_pkg::AVG_FRAC;
      end
    end else begin
      // Output register
      if (out_load) begin
        out_data_r  <= OW'({cnt_r, mask_r, beat_now});
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (win_clr) begin
        win_r   <= win_wr;
        pos_r   <= '0;
        clr_r   <= '0;
        state_r <= ST_CLR;
        for (int i = 0; i < BANDS; i++) begin
          sum_r[i] <= '0;
          sq_r[i]  <= '0;
        end
      end else begin
        case (state_r)
          ST_CLR: begin
            clr_r <= clr_r + 1'b1;
            if (clr_r == AD'(MAX_WINDOW-1)) begin
              state_r <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (in_tvalid) begin
              in_word_r <= in_tdata[HW-1:0];
              state_r   <= ST_RD;
            end
          end
          ST_RD: begin
            state_r <= ST_RDW;
          end
          ST_RDW: begin
            old_word_r <= ram_rdata;
            band_r     <= '0;
            op_r       <= OP_XX;
            mask_r     <= '0;
            state_r    <= ST_MST;
          end
          ST_MST: begin
            state_r <= ST_MWT;
          end
          ST_MWT: begin
            if (mul_done) begin
              state_r <= (op_r == OP_VK && band_r == BNW'(BANDS-1)) ? ST_WB : ST_MST;
              op_r    <= (op_r == OP_VK) ? OP_XX : op_t'(op_r + 4'd1);
              case (op_r)
                OP_XX: xx_r <= mul_p[QW-1:0];
                OP_OO: begin
                  sum_r[band_r] <= s_cur - SW'(old_cur) + SW'(x_cur);
                  sq_r[band_r]  <= q_cur - mul_p[QW-1:0] + xx_r;
                  avg_r[band_r] <= l_upd;
                end
                OP_NF: p_r <= mul_p[BW-1:0];
                OP_NZ: quiet_r <= mul_p < noise_rhs;
                OP_NX: begin
                  dpos_r <= nx > s_cur;
                  d_r    <= BW'(nx - s_cur) << 8;
                end
                OP_NQ: nq_r <= mul_p;
                OP_SS: var_r <= (nq_r < mul_p) ? '0 : nq_r - mul_p;
                OP_DD: dd_r <= mul_p;
                OP_K2: k2_r <= mul_p[BW-1:0];
                OP_VK: begin
                  mask_r[band_r] <= quiet_r && dpos_r && (mul_p < dd_r);
                  if (band_r != BNW'(BANDS-1)) begin
                    band_r <= band_r + 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
          ST_WB: begin
            // history entry written back here; ring advances modulo window
            pos_r <= (pos_inc == (AD+1)'(win_r)) ? '0 : pos_inc[AD-1:0];
            if (beat_now && !prev_r) begin
              cnt_r <= cnt_r + 1'b1;
            end
            prev_r  <= beat_now;
            state_r <= ST_OUT;
          end
          ST_OUT: begin
            if (out_load) begin
              state_r <= ST_IDLE;
            end
          end
          default: state_r <= ST_IDLE;
        endcase
      end

      // Remaining configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          sbd_pkg::REG_NOISE_FACTOR: nf_r <= cfg_wdata[sbd_pkg::NF_W-1:0];
          sbd_pkg::REG_SD_FACTOR:    sd_r <= cfg_wdata[sbd_pkg::SD_W-1:0];
          sbd_pkg::REG_SLOW_SHIFT:   sh_r <= sh_wr;
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

FILE: src/sbd_ram.sv
module sbd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/sbd_mul.sv
module sbd_mul #(
  parameter int AW = 76,
  parameter int BW = 34
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW-1:0] prod
);

  logic [AW-1:0] acc_r;
  logic [AW-1:0] a_r;
  logic [BW-1:0] b_r;
  logic          busy_r;

  // Shift-and-add, one multiplier bit a cycle, stops when no bits are left
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      a_r    <= a;
      b_r    <= b;
      acc_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r <= a_r << 1;
        b_r <= b_r >> 1;
      end
    end
  end

  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

endmodule
